@@ design/sacc_pkg.sv @@
// Types and constants shared by the stepper axis command controller.
// Holds the item structs, the axis state struct, the mode and command codes.
// No dependencies.
package sacc_pkg;

  // Mode codes, as reported in the mode_code field.
  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_WORKING     = 3'd1,
    MODE_ERROR       = 3'd2,
    MODE_MAINTENANCE = 3'd3,
    MODE_CALIBRATING = 3'd4
  } sacc_mode_e;

  // Command codes carried by a command item.
  typedef enum logic [3:0] {
    OP_START      = 4'd0,
    OP_STOP       = 4'd1,
    OP_SET_TARGET = 4'd2,
    OP_SET_SPEED  = 4'd3,
    OP_ESTOP      = 4'd4,
    OP_RESET      = 4'd5,
    OP_STATUS     = 4'd6,
    OP_CALIBRATE  = 4'd7
  } sacc_cmd_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POS_UPPER   = 2'd0;
  localparam logic [1:0] CFG_POS_LOWER   = 2'd1;
  localparam logic [1:0] CFG_SPEED_LIMIT = 2'd2;

  // Reset values.
  localparam logic [7:0]  RST_POS_UPPER   = 8'd100;
  localparam logic [7:0]  RST_POS_LOWER   = 8'd0;
  localparam logic [6:0]  RST_SPEED_LIMIT = 7'd100;
  localparam logic [15:0] RST_FULL_RANGE  = 16'd2000;

  // Step period arithmetic, in microseconds.
  localparam logic [9:0] PERIOD_BASE  = 10'd1000;
  localparam logic [9:0] PERIOD_KNEE  = 10'd800;
  localparam logic [9:0] PERIOD_FLOOR = 10'd200;

  // Input item.
  typedef struct packed {
    logic        action;
    logic [3:0]  command_code;
    logic [7:0]  argument;
    logic [31:0] now_time;
    logic        limit_low_hit;
    logic        limit_high_hit;
  } sacc_in_t;

  // Result item.
  typedef struct packed {
    logic        step_pulse;
    logic        direction_out;
    logic        motor_enable;
    logic [2:0]  mode_code;
    logic [7:0]  position_now;
    logic [6:0]  speed_now;
    logic        fault_code;
    logic        ack_error;
    logic        status_lamp;
    logic        fault_lamp;
    logic [15:0] calibrated_steps;
  } sacc_out_t;

  // Configuration registers.
  typedef struct packed {
    logic [7:0] pos_upper;
    logic [7:0] pos_lower;
    logic [6:0] speed_limit;
  } sacc_cfg_t;

  // Axis state. lamps bit 0 is the status lamp, bit 1 the error lamp.
  typedef struct packed {
    logic [7:0]  position;
    logic [7:0]  target;
    logic [6:0]  speed;
    logic [9:0]  step_period;
    logic        stepping_active;
    logic        enable;
    logic        direction;
    sacc_mode_e  mode;
    logic        fault;
    logic [15:0] steps_taken;
    logic [15:0] full_range_steps;
    logic [31:0] last_step_time;
    logic [1:0]  lamps;
  } sacc_state_t;

endpackage

@@ design/stepper_axis_command_controller_unit.sv @@
// Top level of the stepper axis command controller.
// Holds the input and result registers, the axis state and the configuration
// registers; depends on sacc_pkg and sacc_step.
//
// Usage:
// - in_item_i is a poll (timer value and limit switches) or a command. An item
//   is taken when in_valid_i is high and in_stall_o is low.
// - Every item gives exactly one result on out_item_o, taken when out_valid_o
//   is high and out_stall_i is low.
// - The item is registered, then the state update and the result are computed
//   from that register and the state, and written to the result register.
// - Throughput is one item per cycle while out_stall_i is low. The per-item
//   update is a single pass of logic between the input and result registers,
//   so the state one item writes is ready for the next in the following cycle.
// - When the receiver stalls, the result register holds its item; the input
//   register still takes one more item, then in_stall_o rises until the
//   result is taken.
// - Configuration writes on cfg_* are always ready; indexes 0, 1, 2 are the
//   upper position bound, the lower position bound and the speed limit, other
//   indexes are ignored.
// - Reset (rst_ni low, asynchronous) empties both registers, restores the
//   configuration defaults and puts the axis in idle with both lamps off.
module stepper_axis_command_controller_unit import sacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input items.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sacc_in_t   in_item_i,
  // Result items.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output sacc_out_t  out_item_o,
  // Configuration writes.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  sacc_in_t    in_item_q;
  logic        out_valid_q, out_valid_d;
  sacc_out_t   out_item_q;
  sacc_state_t state_q, state_d;
  sacc_cfg_t   cfg_q, cfg_d;
  sacc_out_t   result;
  logic        advance;
  logic        load;

  // The registered item moves on when the result register is free or emptying.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  // Per-item state update and result.
  sacc_step u_step (
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Handshake control for both registers.
  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  // Axis state, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.position         <= 8'd0;
      state_q.target           <= 8'd0;
      state_q.speed            <= 7'd0;
      state_q.step_period      <= PERIOD_BASE;
      state_q.stepping_active  <= 1'b0;
      state_q.enable           <= 1'b0;
      state_q.direction        <= 1'b0;
      state_q.mode             <= MODE_IDLE;
      state_q.fault            <= 1'b0;
      state_q.steps_taken      <= 16'd0;
      state_q.full_range_steps <= RST_FULL_RANGE;
      state_q.last_step_time   <= 32'd0;
      state_q.lamps            <= 2'b00;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POS_UPPER:   cfg_d.pos_upper   = cfg_data_i;
        CFG_POS_LOWER:   cfg_d.pos_lower   = cfg_data_i;
        CFG_SPEED_LIMIT: cfg_d.speed_limit = cfg_data_i[6:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_upper   <= RST_POS_UPPER;
      cfg_q.pos_lower   <= RST_POS_LOWER;
      cfg_q.speed_limit <= RST_SPEED_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A command never produces a step pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.action) |=> !out_item_q.step_pulse)
    else $error("step pulse reported for a command item");

  // A poll never reports a command error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_item_q.action) |=> !out_item_q.ack_error)
    else $error("ack_error reported for a poll item");

  // Stepping is only active while the driver is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stepping_active |-> state_q.enable)
    else $error("stepping active with driver disabled");

  // Error mode always shows the error lamp alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_ERROR) |-> (state_q.lamps == 2'b10))
    else $error("lamps do not match error mode");

endmodule

@@ design/sacc_step.sv @@
// Next-state and result logic for one item of the stepper axis controller.
// Purely combinational; depends on sacc_pkg for the item and state types.
module sacc_step import sacc_pkg::*; (
  input  sacc_in_t    item_i,
  input  sacc_cfg_t   cfg_i,
  input  sacc_state_t state_i,
  output sacc_state_t state_o,
  output sacc_out_t   result_o
);

  // Lamp levels that go with each mode.
  function automatic logic [1:0] lamps_for_mode(input sacc_mode_e m);
    logic [1:0] l;
    case (m)
      MODE_IDLE, MODE_WORKING: l = 2'b01;
      MODE_ERROR:              l = 2'b10;
      MODE_MAINTENANCE:        l = 2'b00;
      default:                 l = 2'b11;
    endcase
    return l;
  endfunction

  logic [31:0] elapsed;
  logic        step_due;
  logic [7:0]  target_clamped;
  logic [7:0]  speed_clamped;
  logic [9:0]  speed_x8;
  logic        pulse;
  logic        unknown_cmd;
  sacc_state_t n;

  // Time since the last step, wrapping at 32 bits.
  assign elapsed  = item_i.now_time - state_i.last_step_time;
  assign step_due = state_i.stepping_active && (state_i.position != state_i.target) &&
                    (elapsed >= {22'd0, state_i.step_period});

  // Requested target, clamped to the upper bound first and then to the lower.
  always_comb begin
    target_clamped = (item_i.argument > cfg_i.pos_upper) ? cfg_i.pos_upper
                                                         : item_i.argument;
    if (target_clamped < cfg_i.pos_lower) begin
      target_clamped = cfg_i.pos_lower;
    end
  end

  // Requested speed, clamped, and its scaled value for the period.
  assign speed_clamped = (item_i.argument > {1'b0, cfg_i.speed_limit}) ?
                         {1'b0, cfg_i.speed_limit} : item_i.argument;
  assign speed_x8 = {speed_clamped[6:0], 3'b000};

  // State update for a poll or a command.
  always_comb begin
    n           = state_i;
    pulse       = 1'b0;
    unknown_cmd = 1'b0;
    if (!item_i.action) begin
      // Poll: one step toward the target, then the switch snaps.
      if (step_due) begin
        pulse = 1'b1;
        if (state_i.target > state_i.position) begin
          n.position = state_i.position + 8'd1;
        end else begin
          n.position = state_i.position - 8'd1;
        end
        n.steps_taken    = state_i.steps_taken + 16'd1;
        n.last_step_time = item_i.now_time;
      end
      if (item_i.limit_low_hit && (n.position != 8'd0)) begin
        n.position = 8'd0;
        n.target   = 8'd0;
      end
      if (item_i.limit_high_hit && (n.position < cfg_i.pos_upper)) begin
        n.position = cfg_i.pos_upper;
        n.target   = cfg_i.pos_upper;
      end
      if ((state_i.mode == MODE_CALIBRATING) && item_i.limit_high_hit) begin
        n.full_range_steps = n.steps_taken;
        n.mode             = MODE_IDLE;
        n.lamps            = lamps_for_mode(MODE_IDLE);
      end
    end else begin
      case (item_i.command_code)
        OP_START: begin
          if (state_i.mode != MODE_ERROR) begin
            n.mode            = MODE_WORKING;
            n.lamps           = lamps_for_mode(MODE_WORKING);
            n.enable          = 1'b1;
            n.stepping_active = 1'b1;
          end
        end
        OP_STOP: begin
          n.mode            = MODE_IDLE;
          n.lamps           = lamps_for_mode(MODE_IDLE);
          n.enable          = 1'b0;
          n.stepping_active = 1'b0;
          n.speed           = 7'd0;
        end
        OP_SET_TARGET: begin
          n.target    = target_clamped;
          n.direction = target_clamped > state_i.position;
        end
        OP_SET_SPEED: begin
          n.speed = speed_clamped[6:0];
          if (speed_clamped[6:0] == 7'd0) begin
            n.step_period = PERIOD_BASE;
          end else if (speed_x8 >= PERIOD_KNEE) begin
            n.step_period = PERIOD_FLOOR;
          end else begin
            n.step_period = PERIOD_BASE - speed_x8;
          end
        end
        OP_ESTOP: begin
          n.mode            = MODE_ERROR;
          n.lamps           = lamps_for_mode(MODE_ERROR);
          n.enable          = 1'b0;
          n.stepping_active = 1'b0;
          n.speed           = 7'd0;
          n.fault           = 1'b1;
        end
        OP_RESET: begin
          n.mode            = MODE_IDLE;
          n.lamps           = lamps_for_mode(MODE_IDLE);
          n.enable          = 1'b0;
          n.stepping_active = 1'b0;
          n.speed           = 7'd0;
          n.position        = 8'd0;
          n.target          = 8'd0;
          n.fault           = 1'b0;
          n.steps_taken     = 16'd0;
        end
        OP_STATUS: begin
        end
        OP_CALIBRATE: begin
          n.mode        = MODE_CALIBRATING;
          n.lamps       = lamps_for_mode(MODE_CALIBRATING);
          n.direction   = 1'b1;
          n.position    = 8'd0;
          n.steps_taken = 16'd0;
          n.target      = cfg_i.pos_upper;
        end
        default: begin
          unknown_cmd = 1'b1;
        end
      endcase
    end
  end

  assign state_o = n;

  // Result fields come from the state after the item.
  always_comb begin
    result_o.step_pulse       = pulse;
    result_o.direction_out    = n.direction;
    result_o.motor_enable     = n.enable;
    result_o.mode_code        = n.mode;
    result_o.position_now     = n.position;
    result_o.speed_now        = n.speed;
    result_o.fault_code       = n.fault;
    result_o.ack_error        = unknown_cmd;
    result_o.status_lamp      = n.lamps[0];
    result_o.fault_lamp       = n.lamps[1];
    result_o.calibrated_steps = n.full_range_steps;
  end

endmodule
